// ----- rtl/gma_pkg.sv -----
// Shared types, widths and arctangent constants of the gradient magnitude/angle block.
package gma_pkg;

	localparam int MAG_BITS = 16;
	localparam logic [MAG_BITS-1:0] MAG_MAX = '1;

	// Vectoring rotator: 63-bit signed words hold Q58 angles and the scaled vector.
	localparam int CW = 63;
	localparam int CORDIC_STEPS = 58;
	localparam int CORDIC_SPAN = 61;
	localparam int SERIES_TERMS = 32;

	// Angle widths: a quarter turn fits 59 bits, a full turn 61 bits.
	localparam int A_W = 59;
	localparam int TH_W = 61;

	localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;

	typedef struct packed {
		logic x_neg;
		logic y_neg;
		logic x_zero;
		logic y_zero;
	} quad_t;

	typedef logic [CORDIC_STEPS-1:0][63:0] atan_tab_t;

	// Truncating long division; only ever evaluated while building constants
	function automatic logic [63:0] const_div64(input logic [63:0] num,
			input logic [63:0] den);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], num[b]};
			if (r >= {1'b0, den}) begin
				r = r - {1'b0, den};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// atan(2^-sh) in Q62 by the alternating power series
	function automatic logic [63:0] atan_pow2_q62(input int unsigned sh);
		logic [63:0] p;
		logic [63:0] t;
		logic [63:0] k;
		logic [63:0] acc;
		p = ONE_Q62 >> sh;
		k = '0;
		acc = '0;
		for (int n = 0; n < SERIES_TERMS; n++) begin
			if (p != '0) begin
				t = const_div64(p, 64'd2 * k + 64'd1);
				if (k[0]) acc = acc - t;
				else acc = acc + t;
				p = p >> (2 * sh);
				k = k + 64'd1;
			end
		end
		return acc;
	endfunction

	// atan(1/3) in Q62
	function automatic logic [63:0] atan_third_q62();
		logic [63:0] p;
		logic [63:0] t;
		logic [63:0] k;
		logic [63:0] acc;
		p = const_div64(ONE_Q62, 64'd3);
		k = '0;
		acc = '0;
		for (int n = 0; n < SERIES_TERMS; n++) begin
			if (p != '0) begin
				t = const_div64(p, 64'd2 * k + 64'd1);
				if (k[0]) acc = acc - t;
				else acc = acc + t;
				p = const_div64(p, 64'd9);
				k = k + 64'd1;
			end
		end
		return acc;
	endfunction

	localparam logic [63:0] PI4_Q58 = (atan_pow2_q62(1) + atan_third_q62() + 64'd8) >> 4;

	function automatic atan_tab_t build_atan_tab();
		atan_tab_t tab;
		tab[0] = PI4_Q58;
		for (int i = 1; i < CORDIC_STEPS; i++) begin
			tab[i] = (atan_pow2_q62(i) + 64'd8) >> 4;
		end
		return tab;
	endfunction

	localparam atan_tab_t ATAN_TAB = build_atan_tab();

	localparam logic [A_W-1:0] HALF_PI = A_W'(PI4_Q58 * 64'd2);
	localparam logic [TH_W-1:0] PI_Q = TH_W'(PI4_Q58 * 64'd4);
	localparam logic [TH_W-1:0] TWO_PI = TH_W'(PI4_Q58 * 64'd8);

endpackage

// ----- rtl/gma_in_if.sv -----
// Input channel: one pair of image derivatives per item.
interface gma_in_if #(
	parameter int IN_BITS = 16
) ();
	logic valid;
	logic ready;
	logic signed [IN_BITS-1:0] dx_in;
	logic signed [IN_BITS-1:0] dy_in;

	modport source (output valid, output dx_in, output dy_in, input ready);
	modport sink (input valid, input dx_in, input dy_in, output ready);
endinterface

// ----- rtl/gma_out_if.sv -----
// Output channel: gradient magnitude and direction per item.
interface gma_out_if import gma_pkg::*; #(
	parameter int ANGLE_BITS = 16
) ();
	logic valid;
	logic ready;
	logic [MAG_BITS-1:0] magnitude;
	logic [ANGLE_BITS-1:0] direction;

	modport source (output valid, output magnitude, output direction, input ready);
	modport sink (input valid, input magnitude, input direction, output ready);
endinterface

// ----- rtl/gma_mag.sv -----
// Magnitude pipeline: squares, sum and a digit-per-stage rounded square root.
module gma_mag import gma_pkg::*; #(
	parameter int IN_BITS = 16
) (
	input  logic                clk,
	input  logic                en,
	input  logic [IN_BITS-1:0]  xm,
	input  logic [IN_BITS-1:0]  ym,
	output logic [MAG_BITS-1:0] magnitude
);

	localparam int SQ_W = 2 * IN_BITS;

	logic [SQ_W-1:0] xx_s1;
	logic [SQ_W-1:0] yy_s1;
	logic [SQ_W-1:0] rem_s [IN_BITS+1];
	logic [SQ_W-1:0] root_s [IN_BITS+1];
	logic [SQ_W-1:0] rem_c [IN_BITS];
	logic [SQ_W-1:0] root_c [IN_BITS];
	logic [SQ_W:0] root_rnd;
	logic [MAG_BITS-1:0] mag_s;

	// One result bit per stage, trial bit walking down by powers of four
	for (genvar k = 0; k < IN_BITS; k++) begin : g_root
		localparam logic [SQ_W-1:0] BITK = SQ_W'(1) << (SQ_W - 2 - 2 * k);
		logic [SQ_W:0] trial;
		logic fits;
		assign trial = {1'b0, root_s[k]} + {1'b0, BITK};
		assign fits = {1'b0, rem_s[k]} >= trial;
		assign rem_c[k] = fits ? (rem_s[k] - trial[SQ_W-1:0]) : rem_s[k];
		assign root_c[k] = fits ? ((root_s[k] >> 1) + BITK) : (root_s[k] >> 1);
	end

	// Round up when the remainder exceeds the root, then saturate
	assign root_rnd = {1'b0, root_s[IN_BITS]} +
		(SQ_W+1)'(rem_s[IN_BITS] > root_s[IN_BITS]);

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1 <= {{IN_BITS{1'b0}}, xm} * {{IN_BITS{1'b0}}, xm};
			yy_s1 <= {{IN_BITS{1'b0}}, ym} * {{IN_BITS{1'b0}}, ym};
			rem_s[0] <= xx_s1 + yy_s1;
			root_s[0] <= '0;
			for (int k = 0; k < IN_BITS; k++) begin
				rem_s[k+1] <= rem_c[k];
				root_s[k+1] <= root_c[k];
			end
			mag_s <= (root_rnd > (SQ_W+1)'(MAG_MAX)) ? MAG_MAX : root_rnd[MAG_BITS-1:0];
		end
	end

	assign magnitude = mag_s;

endmodule

// ----- rtl/gma_ang.sv -----
// Angle pipeline: vectoring rotator, quadrant mapping and division by a full turn.
module gma_ang import gma_pkg::*; #(
	parameter int IN_BITS = 16,
	parameter int ANGLE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [IN_BITS-1:0]    xm,
	input  logic [IN_BITS-1:0]    ym,
	input  quad_t                 quad,
	output logic                  out_valid,
	output logic [ANGLE_BITS-1:0] direction
);

	localparam int SH = CORDIC_SPAN - IN_BITS;
	localparam int Q_W = ANGLE_BITS + 1;
	localparam int N_ST = CORDIC_STEPS + Q_W + 4;

	logic [N_ST-1:0] v_s;

	logic signed [CW-1:0] x_s [CORDIC_STEPS+1];
	logic signed [CW-1:0] y_s [CORDIC_STEPS+1];
	logic signed [CW-1:0] z_s [CORDIC_STEPS+1];
	quad_t quad_s [CORDIC_STEPS+1];
	logic signed [CW-1:0] x_c [CORDIC_STEPS];
	logic signed [CW-1:0] y_c [CORDIC_STEPS];
	logic signed [CW-1:0] z_c [CORDIC_STEPS];

	logic [A_W-1:0] a_c;
	logic [A_W-1:0] a_s;
	quad_t quad_a_s;
	logic [TH_W-1:0] theta_c;

	logic [TH_W-1:0] rem_d [Q_W+1];
	logic [Q_W-1:0] q_d [Q_W+1];
	logic [TH_W-1:0] rem_c [Q_W];
	logic [Q_W-1:0] q_c [Q_W];
	logic [Q_W:0] q_rnd;
	logic [ANGLE_BITS-1:0] dir_s;

	// Rotate towards the x axis, one micro-rotation per stage
	for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_rot
		localparam logic signed [CW-1:0] ANG = CW'(ATAN_TAB[j]);
		logic signed [CW-1:0] xs;
		logic signed [CW-1:0] ys;
		logic y_neg;
		assign xs = x_s[j] >>> j;
		assign ys = y_s[j] >>> j;
		assign y_neg = y_s[j][CW-1];
		assign x_c[j] = y_neg ? (x_s[j] - ys) : (x_s[j] + ys);
		assign y_c[j] = y_neg ? (y_s[j] + xs) : (y_s[j] - xs);
		assign z_c[j] = y_neg ? (z_s[j] - ANG) : (z_s[j] + ANG);
	end

	// First-quadrant angle: axis cases bypass the rotator, the rest is clamped
	always_comb begin
		if (quad_s[CORDIC_STEPS].y_zero) begin
			a_c = '0;
		end else if (quad_s[CORDIC_STEPS].x_zero) begin
			a_c = HALF_PI;
		end else if (z_s[CORDIC_STEPS][CW-1]) begin
			a_c = '0;
		end else if (z_s[CORDIC_STEPS][CW-2:0] > (CW-1)'(HALF_PI)) begin
			a_c = HALF_PI;
		end else begin
			a_c = z_s[CORDIC_STEPS][A_W-1:0];
		end
	end

	always_comb begin
		if (!quad_a_s.x_neg) begin
			theta_c = quad_a_s.y_neg ? (TWO_PI - TH_W'(a_s)) : TH_W'(a_s);
		end else begin
			theta_c = quad_a_s.y_neg ? (PI_Q + TH_W'(a_s)) : (PI_Q - TH_W'(a_s));
		end
	end

	// Restoring division by a full turn, one quotient bit per stage
	for (genvar k = 0; k < Q_W; k++) begin : g_div
		logic [TH_W:0] rem2;
		logic ge;
		assign rem2 = {rem_d[k], 1'b0};
		assign ge = rem2 >= {1'b0, TWO_PI};
		assign rem_c[k] = ge ? TH_W'(rem2 - {1'b0, TWO_PI}) : rem2[TH_W-1:0];
		assign q_c[k] = {q_d[k][Q_W-2:0], ge};
	end

	// Round half up; the carry out of the top wraps a full turn to zero
	assign q_rnd = {1'b0, q_d[Q_W]} + (Q_W+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[N_ST-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= CW'({xm, {SH{1'b0}}});
			y_s[0] <= CW'({ym, {SH{1'b0}}});
			z_s[0] <= '0;
			quad_s[0] <= quad;
			for (int j = 0; j < CORDIC_STEPS; j++) begin
				x_s[j+1] <= x_c[j];
				y_s[j+1] <= y_c[j];
				z_s[j+1] <= z_c[j];
				quad_s[j+1] <= quad_s[j];
			end
			a_s <= a_c;
			quad_a_s <= quad_s[CORDIC_STEPS];
			rem_d[0] <= theta_c;
			q_d[0] <= '0;
			for (int k = 0; k < Q_W; k++) begin
				rem_d[k+1] <= rem_c[k];
				q_d[k+1] <= q_c[k];
			end
			dir_s <= q_rnd[ANGLE_BITS:1];
		end
	end

	assign out_valid = v_s[N_ST-1];
	assign direction = dir_s;

endmodule

// ----- rtl/gradient_magnitude_angle.sv -----
// Top level: per-pixel gradient magnitude and direction from two image derivatives.
//
// Usage
//   deriv carries one item per pixel: dx_in and dy_in, signed two's complement,
//   rows growing downward. grad returns one item per input item, in order:
//   magnitude = round(sqrt(dx^2 + dy^2)), saturated to 16 bits, and direction,
//   the angle of (dx, -dy) counterclockwise from +x, 2^ANGLE_BITS units a turn.
//   A zero vector gives magnitude 0 and direction 0.
// Throughput and depth
//   One item per clock, sustained while grad is not stalled (see Stall). The
//   58-stage vectoring rotator and the ANGLE_BITS + 1 division stages set the
//   depth of the pipeline. The magnitude path is shorter and is delayed to line
//   up with the angle.
// Reset
//   arst_n clears every valid bit at once; payload registers are left as they are.
//   deriv.ready is high from the first cycle after reset.
// Stall
//   While grad holds a result that is not taken, the whole pipeline holds and
//   deriv.ready drops; nothing is dropped or repeated. Items keep entering when
//   the final stage is empty or being taken in the same cycle.
module gradient_magnitude_angle import gma_pkg::*; #(
	parameter int IN_BITS = 16,
	parameter int ANGLE_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	gma_in_if.sink    deriv,
	gma_out_if.source grad
);

	// Both path depths leave out the input stage below; the magnitude is padded to match
	localparam int ANG_LAT = ANGLE_BITS + CORDIC_STEPS + 5;
	localparam int MAG_LAT = IN_BITS + 3;
	localparam int MAG_DLY = ANG_LAT - MAG_LAT;

	logic en;

	logic [IN_BITS-1:0] dx_u;
	logic [IN_BITS-1:0] dy_u;
	logic dx_neg;
	logic dy_neg;
	logic [IN_BITS-1:0] xm_c;
	logic [IN_BITS-1:0] ym_c;
	quad_t quad_c;

	logic v_s1;
	logic [IN_BITS-1:0] xm_s1;
	logic [IN_BITS-1:0] ym_s1;
	quad_t quad_s1;

	logic [MAG_BITS-1:0] mag_c;
	logic [MAG_BITS-1:0] mag_dly_q [MAG_DLY];
	logic ang_valid;
	logic [ANGLE_BITS-1:0] ang_dir;

	// Advance every stage together whenever the output stage is free or being taken
	assign en = !grad.valid || grad.ready;
	assign deriv.ready = en;

	// Take magnitudes; the most negative value maps onto its own bit pattern
	assign dx_u = deriv.dx_in;
	assign dy_u = deriv.dy_in;
	assign dx_neg = dx_u[IN_BITS-1];
	assign dy_neg = dy_u[IN_BITS-1];
	assign xm_c = dx_neg ? (~dx_u + IN_BITS'(1)) : dx_u;
	assign ym_c = dy_neg ? (~dy_u + IN_BITS'(1)) : dy_u;

	// Image y grows downward, so the vector's y is -dy
	always_comb begin
		quad_c.x_neg = dx_neg;
		quad_c.y_neg = !dy_neg && (dy_u != '0);
		quad_c.x_zero = (dx_u == '0);
		quad_c.y_zero = (dy_u == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= deriv.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xm_s1 <= xm_c;
			ym_s1 <= ym_c;
			quad_s1 <= quad_c;
		end
	end

	gma_mag #(
		.IN_BITS(IN_BITS)
	) u_mag (
		.clk(clk),
		.en(en),
		.xm(xm_s1),
		.ym(ym_s1),
		.magnitude(mag_c)
	);

	gma_ang #(
		.IN_BITS(IN_BITS),
		.ANGLE_BITS(ANGLE_BITS)
	) u_ang (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(v_s1),
		.xm(xm_s1),
		.ym(ym_s1),
		.quad(quad_s1),
		.out_valid(ang_valid),
		.direction(ang_dir)
	);

	// Hold the magnitude back until its angle catches up
	always_ff @(posedge clk) begin
		if (en) begin
			mag_dly_q[0] <= mag_c;
			for (int i = 1; i < MAG_DLY; i++) begin
				mag_dly_q[i] <= mag_dly_q[i-1];
			end
		end
	end

	assign grad.valid = ang_valid;
	assign grad.magnitude = mag_dly_q[MAG_DLY-1];
	assign grad.direction = ang_dir;

endmodule

// ----- bench/grad_polar_checker.sv -----
// Watches both channels, predicts magnitude and direction per item and compares results in order.
module grad_polar_checker import gma_pkg::*; #(
	parameter int IN_BITS = 16,
	parameter int ANGLE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	gma_in_if    deriv,
	gma_out_if   grad,
	output int   fail_count,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROT_STEPS = 58;
	localparam int SCALE_SH = 61 - IN_BITS;

	typedef struct packed {
		logic [MAG_BITS-1:0]   magnitude;
		logic [ANGLE_BITS-1:0] direction;
	} polar_t;

	logic [63:0] arctan_q58 [ROT_STEPS];
	logic [63:0] quarter_pi;
	polar_t      polar_due [$];

	// atan(1/n) in Q62, alternating series, n >= 2
	function automatic logic [63:0] arctan_recip_q62(input logic [63:0] n);
		logic [63:0] p;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] k;
		p = 64'h4000_0000_0000_0000 / n;
		sum = '0;
		k = '0;
		while (p != '0) begin
			term = p / (64'd2 * k + 64'd1);
			if (k[0]) sum = sum - term;
			else sum = sum + term;
			p = p / n / n;
			k = k + 64'd1;
		end
		return sum;
	endfunction

	initial begin
		quarter_pi = (arctan_recip_q62(64'd2) + arctan_recip_q62(64'd3) + 64'd8) >> 4;
		arctan_q58[0] = quarter_pi;
		for (int i = 1; i < ROT_STEPS; i++)
			arctan_q58[i] = (arctan_recip_q62(64'd1 << i) + 64'd8) >> 4;
	end

	function automatic logic [63:0] rounded_root(input logic [63:0] s);
		logic [63:0] r;
		logic [63:0] bitpos;
		logic [63:0] rem;
		r = '0;
		bitpos = 64'd1 << 62;
		rem = s;
		while (bitpos > rem) bitpos = bitpos >> 2;
		while (bitpos != '0) begin
			if (rem >= r + bitpos) begin
				rem = rem - (r + bitpos);
				r = (r >> 1) + bitpos;
			end else begin
				r = r >> 1;
			end
			bitpos = bitpos >> 2;
		end
		if (rem > r) r = r + 64'd1;
		return r;
	endfunction

	// first-quadrant angle of two nonzero magnitudes, Q58 radians
	function automatic logic [63:0] quadrant_angle(input logic [63:0] xm, input logic [63:0] ym);
		logic [63:0] x;
		logic [63:0] y;
		logic [63:0] z;
		logic [63:0] xs;
		logic [63:0] ys;
		x = xm << SCALE_SH;
		y = ym << SCALE_SH;
		z = '0;
		for (int i = 0; i < ROT_STEPS; i++) begin
			xs = x >> i;
			ys = $signed(y) >>> i;
			if (!y[63]) begin
				x = x + ys;
				y = y - xs;
				z = z + arctan_q58[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - arctan_q58[i];
			end
		end
		if (z[63]) z = '0;
		if (z > 64'd2 * quarter_pi) z = 64'd2 * quarter_pi;
		return z;
	endfunction

	function automatic polar_t polar_of_derivs(input logic [IN_BITS-1:0] dx,
			input logic [IN_BITS-1:0] dy);
		polar_t      res;
		logic [63:0] xm;
		logic [63:0] ym;
		logic [63:0] mag;
		logic [63:0] a;
		logic [63:0] theta;
		logic [63:0] rem;
		logic [63:0] q;
		logic [63:0] full_turn;
		logic        x_neg;
		logic        y_neg;
		x_neg = dx[IN_BITS-1];
		xm = x_neg ? ((64'd1 << IN_BITS) - 64'(dx)) : 64'(dx);
		ym = dy[IN_BITS-1] ? ((64'd1 << IN_BITS) - 64'(dy)) : 64'(dy);
		// y is -dy: positive dy points below the axis
		y_neg = !dy[IN_BITS-1] && (ym != '0);
		mag = rounded_root(xm * xm + ym * ym);
		if (mag > 64'(MAG_MAX)) mag = 64'(MAG_MAX);
		res.magnitude = mag[MAG_BITS-1:0];
		if (xm == '0 && ym == '0) begin
			res.direction = '0;
			return res;
		end
		if (ym == '0) a = '0;
		else if (xm == '0) a = 64'd2 * quarter_pi;
		else a = quadrant_angle(xm, ym);
		full_turn = 64'd8 * quarter_pi;
		if (!x_neg) theta = y_neg ? (full_turn - a) : a;
		else theta = y_neg ? (64'd4 * quarter_pi + a) : (64'd4 * quarter_pi - a);
		rem = theta;
		q = '0;
		for (int i = 0; i < ANGLE_BITS + 1; i++) begin
			rem = rem << 1;
			q = q << 1;
			if (rem >= full_turn) begin
				rem = rem - full_turn;
				q[0] = 1'b1;
			end
		end
		q = (q + 64'd1) >> 1;
		res.direction = q[ANGLE_BITS-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		polar_t want;
		if (!arst_n) begin
			polar_due.delete();
			pending <= 0;
		end else begin
			// compare before queueing, so a same-cycle item never matches itself
			if (grad.valid && grad.ready) begin
				if (polar_due.size() == 0) begin
					$error("unexpected result: magnitude %0d, direction %0d",
						grad.magnitude, grad.direction);
					fail_count++;
				end else begin
					want = polar_due.pop_front();
					if (grad.magnitude !== want.magnitude) begin
						$error("magnitude: expected %0d, actual %0d",
							want.magnitude, grad.magnitude);
						fail_count++;
					end
					if (grad.direction !== want.direction) begin
						$error("direction: expected %0d, actual %0d",
							want.direction, grad.direction);
						fail_count++;
					end
				end
			end
			if (deriv.valid && deriv.ready)
				polar_due.push_back(polar_of_derivs(deriv.dx_in, deriv.dy_in));
			pending <= polar_due.size();
		end
	end

endmodule

// ----- bench/tb.sv -----
// Stimulus and verdict for the gradient magnitude and direction block.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gma_pkg::*;

	localparam int IN_BITS = 16;
	localparam int ANGLE_BITS = 16;
	localparam int LATENCY = ANGLE_BITS + 64;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 382;
	localparam int N_DIRECTED = 24;

	// Axes, corners, unit steps, diagonals and vectors just either side of +x,
	// where the angle rounds up to a full turn and must wrap to zero.
	localparam int DIRECTED_DX[N_DIRECTED] = '{
		0, 32767, -32768, 0, 0, 32767, -32768, -32768,
		32767, 1, -1, 0, 0, 1, -1, 1,
		-1, 32767, 32767, -32768, -32768, 3, -12345, 1
	};
	localparam int DIRECTED_DY[N_DIRECTED] = '{
		0, 0, 0, 32767, -32768, 32767, -32768, 32767,
		-32768, 0, 0, 1, -1, 1, 1, -1,
		-1, 1, -1, 1, -1, -4, 6789, -32768
	};
	localparam int EDGE_VALS[8] = '{-32768, -32767, -2, -1, 0, 1, 32766, 32767};

	// Idle and stall odds per random phase, in percent.
	localparam int IDLE_PCT[4] = '{0, 74, 0, 6};
	localparam int STALL_PCT[4] = '{0, 0, 74, 6};

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   idle_pct;
	int   stall_pct;
	int   cycle_count;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	gma_in_if #(.IN_BITS(IN_BITS)) deriv_ch ();
	gma_out_if #(.ANGLE_BITS(ANGLE_BITS)) grad_ch ();

	gradient_magnitude_angle #(
		.IN_BITS(IN_BITS),
		.ANGLE_BITS(ANGLE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.deriv(deriv_ch),
		.grad(grad_ch)
	);

	grad_polar_checker #(
		.IN_BITS(IN_BITS),
		.ANGLE_BITS(ANGLE_BITS)
	) monitor (
		.clk(clk),
		.arst_n(arst_n),
		.deriv(deriv_ch),
		.grad(grad_ch),
		.fail_count(fail_count),
		.pending(pending)
	);

	// Watchdog: give up well beyond the slowest legitimate run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Offer one item, idling first at the current odds; return at the edge that
	// takes it, leaving valid high so a back-to-back item needs no toggle.
	task automatic push_deriv(input int dx, input int dy);
		while ($urandom_range(0, 99) < idle_pct) begin
			deriv_ch.valid <= 1'b0;
			@(posedge clk);
		end
		deriv_ch.valid <= 1'b1;
		deriv_ch.dx_in <= IN_BITS'(dx);
		deriv_ch.dy_in <= IN_BITS'(dy);
		@(posedge clk);
		while (!deriv_ch.ready) @(posedge clk);
	endtask

	// Hold the sender off until every outstanding item has come back.
	task automatic drain_pipeline();
		deriv_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Mix of full-range pairs with the corners of the behaviour: tiny vectors,
	// single axes, field extremes, near-diagonals and near-axis vectors.
	task automatic random_pair(output int dx, output int dy);
		int m;
		int s;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				dx = int'($urandom_range(0, 65535)) - 32768;
				dy = int'($urandom_range(0, 65535)) - 32768;
			end
			4, 5: begin
				dx = int'($urandom_range(0, 16)) - 8;
				dy = int'($urandom_range(0, 16)) - 8;
			end
			6: begin
				m = int'($urandom_range(0, 65535)) - 32768;
				if ($urandom_range(0, 1) == 1) begin
					dx = m;
					dy = 0;
				end else begin
					dx = 0;
					dy = m;
				end
			end
			7: begin
				dx = EDGE_VALS[$urandom_range(0, 7)];
				dy = EDGE_VALS[$urandom_range(0, 7)];
			end
			8: begin
				m = int'($urandom_range(1, 32766));
				s = m + int'($urandom_range(0, 2)) - 1;
				dx = ($urandom_range(0, 1) == 1) ? m : -m;
				dy = ($urandom_range(0, 1) == 1) ? s : -s;
			end
			default: begin
				m = int'($urandom_range(0, 65535)) - 32768;
				s = int'($urandom_range(0, 6)) - 3;
				if ($urandom_range(0, 1) == 1) begin
					dx = m;
					dy = s;
				end else begin
					dx = s;
					dy = m;
				end
			end
		endcase
	endtask

	initial begin : stimulus
		int dx;
		int dy;
		deriv_ch.valid = 1'b0;
		deriv_ch.dx_in = '0;
		deriv_ch.dy_in = '0;
		grad_ch.ready = 1'b0;
		arst_n = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Receiver: stall each cycle at the odds of the current phase.
		fork
			forever begin
				@(posedge clk);
				grad_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		join_none

		// Directed corners at full rate.
		for (int i = 0; i < N_DIRECTED; i++)
			push_deriv(DIRECTED_DX[i], DIRECTED_DY[i]);
		drain_pipeline();

		// Random phases; drain at each boundary, and once mid-phase while the
		// sender is idling heavily.
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = IDLE_PCT[ph];
			stall_pct = STALL_PCT[ph];
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				random_pair(dx, dy);
				push_deriv(dx, dy);
				if (ph == 1 && n == PHASE_ITEMS / 2)
					drain_pipeline();
			end
			drain_pipeline();
		end

		// Let any stray result surface before the verdict.
		stall_pct = 0;
		repeat (LATENCY + 20) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
